// ----- design/mte_pkg.sv -----
package mte_pkg;

  // One output symbol code.
  typedef logic [2:0] sym_t;

  localparam sym_t SymDot     = 3'd0;
  localparam sym_t SymDash    = 3'd1;
  localparam sym_t SymUnknown = 3'd2;
  localparam sym_t SymSpace   = 3'd3;
  localparam sym_t SymSlash   = 3'd4;

  // Longest code, and most symbols that one character can produce.
  localparam int MaxCodeLen = 5;
  localparam int MaxSyms    = 8;
  localparam int CntW       = $clog2(MaxSyms + 1);

  // ASCII landmarks.
  localparam logic [7:0] ChUpperA   = 8'h41;
  localparam logic [7:0] ChUpperZ   = 8'h5a;
  localparam logic [7:0] ChLowerA   = 8'h61;
  localparam logic [7:0] ChLowerZ   = 8'h7a;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;
  localparam logic [7:0] CaseOffset = 8'd32;

  // Packed code: pattern bit 0 is the first symbol, 1 means dash.
  // A length of zero means the byte has no code.
  typedef struct packed {
    logic [4:0] pat;
    logic [2:0] len;
  } code_t;

  localparam code_t LetterCodes [26] = '{
    '{5'h02, 3'd2}, '{5'h01, 3'd4}, '{5'h05, 3'd4}, '{5'h01, 3'd3},
    '{5'h00, 3'd1}, '{5'h04, 3'd4}, '{5'h03, 3'd3}, '{5'h00, 3'd4},
    '{5'h00, 3'd2}, '{5'h0e, 3'd4}, '{5'h05, 3'd3}, '{5'h02, 3'd4},
    '{5'h03, 3'd2}, '{5'h01, 3'd2}, '{5'h07, 3'd3}, '{5'h06, 3'd4},
    '{5'h0b, 3'd4}, '{5'h02, 3'd3}, '{5'h00, 3'd3}, '{5'h01, 3'd1},
    '{5'h04, 3'd3}, '{5'h08, 3'd4}, '{5'h06, 3'd3}, '{5'h09, 3'd4},
    '{5'h0d, 3'd4}, '{5'h03, 3'd4}
  };

  localparam code_t DigitCodes [10] = '{
    '{5'h1f, 3'd5}, '{5'h1e, 3'd5}, '{5'h1c, 3'd5}, '{5'h18, 3'd5},
    '{5'h10, 3'd5}, '{5'h00, 3'd5}, '{5'h01, 3'd5}, '{5'h03, 3'd5},
    '{5'h07, 3'd5}, '{5'h0f, 3'd5}
  };

  // Folds upper case to lower case and looks up the Morse code.
  function automatic code_t lookup_code(input logic [7:0] c);
    logic [7:0] f;
    logic [7:0] li;
    logic [7:0] di;
    code_t      r;
    f  = (c >= ChUpperA && c <= ChUpperZ) ? c + CaseOffset : c;
    li = f - ChLowerA;
    di = f - ChZero;
    r  = '0;
    if (f >= ChLowerA && f <= ChLowerZ) begin
      r = LetterCodes[li[4:0]];
    end else if (f >= ChZero && f <= ChNine) begin
      r = DigitCodes[di[3:0]];
    end
    return r;
  endfunction

endpackage

// ----- design/morse_text_encoder.sv -----
// Morse text encoder.
// Input: one text byte per beat on char_code_i with word_end_i and text_end_i,
// taken at a rising edge where start is high and busy is low.
// Output: one symbol per cycle on symbol_o (dot, dash, unknown marker, space,
// slash) while strobe_o is high; last_o marks the final symbol of a character.
// A character yields its code (or one unknown marker), then a space, and at a
// word end a slash and a space; on the text end the separators are dropped.
// Latency: the first symbol appears in the cycle after the beat is taken.
// Throughput: a character yields 1 to 8 symbols, one per cycle as set
// by the single-symbol result port. The next character is taken
// in the cycle its predecessor shows last_o, so symbols stream without gaps.
// The symbol sequence is built in one pass from the input and held in a
// shift register that drains one symbol a cycle.
// Reset clears the symbol count: no strobe and busy low afterwards.
// The receiver cannot stall; every strobed symbol is taken.
module morse_text_encoder
  import mte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] char_code_i,
  input  logic       word_end_i,
  input  logic       text_end_i,
  output logic       strobe_o,
  output logic [2:0] symbol_o,
  output logic       last_o
);

  sym_t            seq_q [MaxSyms];
  sym_t            seq_d [MaxSyms];
  logic [CntW-1:0] rem_q, rem_d;
  code_t           code;
  logic            known;
  logic [2:0]      clen;
  logic [7:0]      pat_ext;
  logic [CntW-1:0] pos;
  logic [CntW-1:0] offs;
  logic            accept;

  // Handshake: a new beat is taken when idle or while the last pending symbol goes out.
  assign busy     = rem_q > CntW'(1);
  assign accept   = start && !busy;
  assign strobe_o = rem_q != '0;
  assign last_o   = rem_q == CntW'(1);
  assign symbol_o = seq_q[0];

  // Build the whole symbol sequence of a character, or drain one symbol.
  always_comb begin
    code    = lookup_code(char_code_i);
    known   = code.len != 3'd0;
    clen    = known ? code.len : 3'd1;
    pat_ext = {3'b000, code.pat};
    rem_d   = rem_q;
    pos     = '0;
    offs    = '0;
    for (int p = 0; p < MaxSyms; p++) begin
      seq_d[p] = SymDot;
    end
    if (accept) begin
      for (int p = 0; p < MaxSyms; p++) begin
        pos  = CntW'(p);
        offs = pos - CntW'(clen);
        if (pos < CntW'(clen)) begin
          seq_d[p] = !known ? SymUnknown : (pat_ext[p] ? SymDash : SymDot);
        end else if (offs == CntW'(1)) begin
          seq_d[p] = SymSlash;
        end else begin
          seq_d[p] = SymSpace;
        end
      end
      rem_d = CntW'(clen) + (text_end_i ? CntW'(0) : (word_end_i ? CntW'(3) : CntW'(1)));
    end else if (rem_q != '0) begin
      for (int p = 0; p < MaxSyms - 1; p++) begin
        seq_d[p] = seq_q[p + 1];
      end
      rem_d = rem_q - CntW'(1);
    end else begin
      for (int p = 0; p < MaxSyms; p++) begin
        seq_d[p] = seq_q[p];
      end
    end
  end

  // Symbol count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // Symbol shift register.
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < MaxSyms; p++) begin
      seq_q[p] <= seq_d[p];
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CntW'(MaxSyms))
    else $error("symbol count out of range");

  a_accept_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> strobe_o)
    else $error("no symbol after an accepted beat");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |=> strobe_o)
    else $error("symbols of one character interrupted");

  a_busy_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (strobe_o && !last_o))
    else $error("busy without pending symbols");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !accept) |=> rem_q == $past(rem_q) - CntW'(1))
    else $error("symbol count did not step down");
`endif

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import mte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One character beat as the sender presents it.
  typedef struct {
    logic [7:0] ch;
    logic       we;
    logic       te;
    bit         hold;
  } char_beat_t;

  // One expected output symbol.
  typedef struct {
    sym_t symbol;
    logic last;
  } morse_sym_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] char_code_i = 8'h00;
  logic       word_end_i = 1'b0;
  logic       text_end_i = 1'b0;
  logic       strobe_o;
  logic [2:0] symbol_o;
  logic       last_o;

  morse_text_encoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .char_code_i(char_code_i),
    .word_end_i (word_end_i),
    .text_end_i (text_end_i),
    .strobe_o   (strobe_o),
    .symbol_o   (symbol_o),
    .last_o     (last_o)
  );

  char_beat_t chars_q[$];
  morse_sym_t symbols_due[$];
  int         errors = 0;
  int         burst_left = 0;
  int         gap_left = 0;

  // The beat taken at the last edge, handed from the driver to the monitor.
  logic       beat_taken = 1'b0;
  logic [7:0] beat_ch = 8'h00;
  logic       beat_we = 1'b0;
  logic       beat_te = 1'b0;

  // International Morse code, written as dot and dash text.
  string letter_morse[26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_morse[10] = '{
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----."
  };

  // Clock and the single reset at the start of the run.
  always #4 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Work out the symbols that one character beat produces.
  function automatic void predict_symbols(input logic [7:0] ch, input logic we,
                                          input logic te);
    logic [7:0] f;
    string      code;
    sym_t       syms[$];
    morse_sym_t e;
    f = (ch >= ChUpperA && ch <= ChUpperZ) ? ch + CaseOffset : ch;
    code = "";
    if (f >= ChLowerA && f <= ChLowerZ) begin
      code = letter_morse[f - ChLowerA];
    end else if (f >= ChZero && f <= ChNine) begin
      code = digit_morse[f - ChZero];
    end
    if (code.len() == 0) begin
      syms.push_back(SymUnknown);
    end else begin
      for (int i = 0; i < code.len(); i++) begin
        syms.push_back((code[i] == "-") ? SymDash : SymDot);
      end
    end
    // The text end drops every separator, with or without a word end.
    if (!te) begin
      syms.push_back(SymSpace);
      if (we) begin
        syms.push_back(SymSlash);
        syms.push_back(SymSpace);
      end
    end
    foreach (syms[i]) begin
      e.symbol = syms[i];
      e.last   = (i == syms.size() - 1);
      symbols_due.push_back(e);
    end
  endfunction

  // Driver: bursts of beats with random gaps; a held beat waits for a drained block.
  always @(posedge clk_i) begin
    logic       take;
    logic       hold_cur;
    logic       load;
    char_beat_t nxt;
    take     = rst_ni && start && !busy;
    hold_cur = start && !take;
    load     = 1'b0;
    if (take) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = 0;
        gap_left   = $urandom_range(0, 12);
      end
    end
    if (rst_ni && !hold_cur && chars_q.size() > 0) begin
      if (burst_left == 0 && gap_left > 0) begin
        gap_left--;
      end else if (!chars_q[0].hold ||
                   (symbols_due.size() == 0 && !beat_taken && !take)) begin
        load = 1'b1;
        nxt  = chars_q.pop_front();
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
      end
    end
    start      <= hold_cur || load;
    beat_taken <= take;
    if (take) begin
      beat_ch <= char_code_i;
      beat_we <= word_end_i;
      beat_te <= text_end_i;
    end
    // Idle cycles carry random data that the block must ignore.
    if (load) begin
      char_code_i <= nxt.ch;
      word_end_i  <= nxt.we;
      text_end_i  <= nxt.te;
    end else if (!hold_cur) begin
      char_code_i <= 8'($urandom);
      word_end_i  <= 1'($urandom);
      text_end_i  <= 1'($urandom);
    end
  end

  // Monitor: predict the last beat, then check each strobed symbol.
  always @(posedge clk_i) begin
    morse_sym_t e;
    if (beat_taken) predict_symbols(beat_ch, beat_we, beat_te);
    if (rst_ni && strobe_o) begin
      if (symbols_due.size() == 0) begin
        report_mismatch("symbol with nothing expected", symbol_o, -1);
      end else begin
        e = symbols_due.pop_front();
        if (symbol_o !== e.symbol) report_mismatch("symbol", symbol_o, e.symbol);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
      end
    end
  end

  task automatic add_char(input logic [7:0] ch, input logic we, input logic te,
                          input bit hold = 0);
    char_beat_t b;
    b.ch   = ch;
    b.we   = we;
    b.te   = te;
    b.hold = hold;
    chars_q.push_back(b);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: c = ChUpperA + 8'($urandom_range(0, 25));
      1: c = ChLowerA + 8'($urandom_range(0, 25));
      2: c = ChZero + 8'($urandom_range(0, 9));
      3: c = ChLowerA + 8'($urandom_range(0, 25));
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Stimulus, then the wait for the last symbols and the verdict.
  initial begin
    int n;
    int words;
    int wlen;
    logic early_end;
    // Letter and digit edges, case folding, and bytes just outside each range.
    add_char(ChUpperA, 1'b0, 1'b0);
    add_char(ChUpperZ, 1'b0, 1'b0);
    add_char(ChLowerA, 1'b0, 1'b0);
    add_char(ChLowerZ, 1'b1, 1'b0);
    add_char(ChZero, 1'b0, 1'b0);
    add_char(ChNine, 1'b1, 1'b0);
    add_char(8'h45, 1'b0, 1'b0);
    add_char(8'h74, 1'b1, 1'b0);
    add_char(ChUpperA - 8'd1, 1'b0, 1'b0);
    add_char(ChUpperZ + 8'd1, 1'b0, 1'b0);
    add_char(ChLowerA - 8'd1, 1'b0, 1'b0);
    add_char(ChLowerZ + 8'd1, 1'b0, 1'b0);
    add_char(ChZero - 8'd1, 1'b0, 1'b0);
    add_char(ChNine + 8'd1, 1'b1, 1'b0);
    // High bytes and the extremes of the byte range give the unknown marker.
    add_char(8'h00, 1'b0, 1'b0);
    add_char(8'h7f, 1'b0, 1'b0);
    add_char(8'h80, 1'b0, 1'b0);
    add_char(8'hc1, 1'b0, 1'b0);
    add_char(8'hff, 1'b1, 1'b0);
    // Text end with and without word end, on a code and on the marker.
    add_char(ChZero, 1'b0, 1'b1);
    add_char(8'h51, 1'b1, 1'b1);
    add_char(8'hff, 1'b0, 1'b1);
    add_char(8'h20, 1'b1, 1'b1, 1);

    // Random texts of random words, with some noise beats between them.
    n = 0;
    while (n < 330) begin
      if ($urandom_range(0, 9) < 8) begin
        words     = $urandom_range(1, 4);
        early_end = ($urandom_range(0, 5) == 0);
        for (int w = 0; w < words; w++) begin
          wlen = $urandom_range(1, 6);
          for (int k = 0; k < wlen; k++) begin
            if (k == wlen - 1 && w == words - 1) begin
              add_char(pick_char(), !early_end, 1'b1, (w == 0 && k == 0 && n % 97 < 6));
            end else begin
              add_char(pick_char(), k == wlen - 1, 1'b0,
                       (w == 0 && k == 0 && n % 97 < 6));
            end
            n++;
          end
        end
      end else begin
        add_char(8'($urandom), 1'($urandom), 1'($urandom));
        n++;
      end
    end

    @(posedge rst_ni);
    while (chars_q.size() > 0 || start || beat_taken || symbols_due.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("morse_text_encoder test passed");
    end else begin
      $display("morse_text_encoder test failed");
    end
    $finish;
  end

  // Watchdog for a block that hangs or never strobes.
  initial begin
    #2000000;
    $display("morse_text_encoder test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mte_pkg.sv
design/morse_text_encoder.sv
tb/sv/tb.sv
